>>> design/gtam_pkg.sv
// package for the greedy text alignment marker: codes, states and defaults
package gtam_pkg;

   localparam int MaxLenDefault    = 256;
   localparam int MatchRunDefault  = 2;
   localparam int LookaheadDefault = 3;

   localparam logic [2:0] OP_APPEND_USER = 3'd0;
   localparam logic [2:0] OP_APPEND_SENT = 3'd1;
   localparam logic [2:0] OP_COMPARE     = 3'd2;
   localparam logic [2:0] OP_READ        = 3'd3;
   localparam logic [2:0] OP_CLEAR       = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RESPOND,
      ST_LOOP,
      ST_RUN_CHK,
      ST_WIN_START,
      ST_WIN_RD,
      ST_WIN_CMP,
      ST_MARK,
      ST_TAIL_U,
      ST_TAIL_S
   } state_type;

   typedef enum logic [1:0] {
      PH_DIRECT,
      PH_SENT,
      PH_USER
   } phase_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

>>> design/greedy_text_alignment_marker_core.sv
// top level: string buffers, mark buffers and the compare sequencer
//
// Every op returns exactly one result, shown for one cycle under rsp_valid; the receiver
// cannot stall it. Loads, reads, clear and unused ops show their result in the cycle after
// the transfer, and the next transfer is taken once busy has dropped again. Compare
// runs a sequencer over one shared window comparator with one read port per string buffer:
// an in-run character passes through the loop, run check and mark states, a window check
// reads and compares up to MATCH_RUN character pairs (none if it runs past a string end),
// each mark is written in its own step, and the tails are marked one character per cycle.
// busy stays high through the result cycle.
module greedy_text_alignment_marker_core
   import gtam_pkg::*;
#(
   parameter int MAX_LEN   = MaxLenDefault,
   parameter int MATCH_RUN = MatchRunDefault,
   parameter int LOOKAHEAD = LookaheadDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_op,
   input  logic [7:0] req_char_value,
   input  logic [7:0] req_index,
   output logic       rsp_valid,
   output logic       rsp_user_style,
   output logic       rsp_sent_style,
   output logic       rsp_user_in_range,
   output logic       rsp_sent_in_range,
   output logic [8:0] rsp_user_count,
   output logic [8:0] rsp_sent_count,
   output logic       rsp_overflow,
   output logic       rsp_compared
);

   localparam int AW   = $clog2(MAX_LEN);
   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int PW   = $clog2(MAX_LEN + LOOKAHEAD + MATCH_RUN + 1);
   localparam int KW   = $clog2(MATCH_RUN + 1);
   localparam int IW   = $clog2(LOOKAHEAD + 1);
   localparam int CMAX = (MATCH_RUN > LOOKAHEAD) ? MATCH_RUN : LOOKAHEAD;
   localparam int CW   = $clog2(CMAX + 1);

   logic [7:0] user_chars [MAX_LEN];
   logic [7:0] sent_chars [MAX_LEN];
   logic       user_marks [MAX_LEN];
   logic       sent_marks [MAX_LEN];

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [LW-1:0] ulen_ff, ulen_in, slen_ff, slen_in;
   logic          ovf_ff, ovf_in, done_ff, done_in;
   logic [PW-1:0] u_ff, u_in, s_ff, s_in;
   logic          streak_ff, streak_in;
   logic [KW-1:0] k_ff, k_in;
   logic [IW-1:0] i_ff, i_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          mu_ff, mu_in, ms_ff, ms_in, mval_ff, mval_in;
   logic          rd_op_ff, rd_op_in, ur_ff, ur_in, sr_ff, sr_in;
   logic [7:0]    uch_ff, sch_ff;
   logic          umk_ff, smk_ff;

   logic          accept;
   logic [PW-1:0] wa, wb, ulen_p, slen_p;
   logic [PW+7:0] idx_ext;
   logic [LW+7:0] ulen_x, slen_x;
   logic [AW-1:0] rd_u_addr, rd_s_addr;
   logic          win_end, win_ok;
   logic          user_full, sent_full;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign ulen_p    = PW'(ulen_ff);
   assign slen_p    = PW'(slen_ff);
   assign idx_ext   = {PW'(0), req_index};
   assign ulen_x    = {8'(0), ulen_ff};
   assign slen_x    = {8'(0), slen_ff};
   assign user_full = (ulen_ff == LW'(MAX_LEN));
   assign sent_full = (slen_ff == LW'(MAX_LEN));
   assign wa = u_ff + ((phase_ff == PH_USER) ? PW'(i_ff) : PW'(0));
   assign wb = s_ff + ((phase_ff == PH_SENT) ? PW'(i_ff) : PW'(0));

   // read address mux
   always_comb begin
      rd_u_addr = idx_ext[AW-1:0];
      rd_s_addr = idx_ext[AW-1:0];
      if (state_ff == ST_LOOP) begin
         rd_u_addr = u_ff[AW-1:0];
         rd_s_addr = s_ff[AW-1:0];
      end else if (state_ff == ST_WIN_RD) begin
         rd_u_addr = AW'(wa + PW'(k_ff));
         rd_s_addr = AW'(wb + PW'(k_ff));
      end
   end

   // window comparator result
   always_comb begin
      win_end = 1'b0;
      win_ok  = 1'b0;
      if (state_ff == ST_WIN_START) begin
         if ((wa + PW'(MATCH_RUN) > ulen_p) || (wb + PW'(MATCH_RUN) > slen_p)) begin
            win_end = 1'b1;
         end
      end else if (state_ff == ST_WIN_CMP) begin
         if (uch_ff != sch_ff) begin
            win_end = 1'b1;
         end else if (k_ff == KW'(MATCH_RUN - 1)) begin
            win_end = 1'b1;
            win_ok  = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_COMPARE) ? ST_LOOP : ST_RESPOND;
            end
         end
         ST_RESPOND: state_in = ST_IDLE;
         ST_LOOP: begin
            if (u_ff < ulen_p && s_ff < slen_p) begin
               state_in = streak_ff ? ST_RUN_CHK : ST_WIN_START;
            end else begin
               state_in = ST_TAIL_U;
            end
         end
         ST_RUN_CHK: state_in = (uch_ff == sch_ff) ? ST_MARK : ST_WIN_START;
         ST_WIN_START, ST_WIN_CMP: begin
            if (win_end) begin
               if (win_ok || phase_ff != PH_USER || i_ff == IW'(LOOKAHEAD)) begin
                  state_in = (win_ok || phase_ff == PH_USER) ? ST_MARK : ST_WIN_START;
               end else begin
                  state_in = ST_WIN_START;
               end
            end else begin
               state_in = ST_WIN_RD;
            end
         end
         ST_WIN_RD: state_in = ST_WIN_CMP;
         ST_MARK: begin
            if (cnt_ff == CW'(1)) begin
               state_in = ST_LOOP;
            end
         end
         ST_TAIL_U: begin
            if (!(u_ff < ulen_p)) begin
               state_in = ST_TAIL_S;
            end
         end
         ST_TAIL_S: begin
            if (!(s_ff < slen_p)) begin
               state_in = ST_RESPOND;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      phase_in  = phase_ff;
      ulen_in   = ulen_ff;
      slen_in   = slen_ff;
      ovf_in    = ovf_ff;
      done_in   = done_ff;
      u_in      = u_ff;
      s_in      = s_ff;
      streak_in = streak_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      cnt_in    = cnt_ff;
      mu_in     = mu_ff;
      ms_in     = ms_ff;
      mval_in   = mval_ff;
      rd_op_in  = rd_op_ff;
      ur_in     = ur_ff;
      sr_in     = sr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_op_in = (req_op == OP_READ);
               ur_in    = (req_op == OP_READ) && (idx_ext < PW'(ulen_x));
               sr_in    = (req_op == OP_READ) && (idx_ext < PW'(slen_x));
               u_in      = '0;
               s_in      = '0;
               streak_in = 1'b0;
               case (req_op)
                  OP_APPEND_USER: begin
                     if (user_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        ulen_in = ulen_ff + LW'(1);
                        done_in = 1'b0;
                     end
                  end
                  OP_APPEND_SENT: begin
                     if (sent_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        slen_in = slen_ff + LW'(1);
                        done_in = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     ulen_in = '0;
                     slen_in = '0;
                     ovf_in  = 1'b0;
                     done_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOP: begin
            phase_in = PH_DIRECT;
            k_in     = '0;
         end
         ST_RUN_CHK: begin
            if (uch_ff == sch_ff) begin
               cnt_in  = CW'(1);
               mu_in   = 1'b1;
               ms_in   = 1'b1;
               mval_in = 1'b0;
            end else begin
               streak_in = 1'b0;
               phase_in  = PH_DIRECT;
            end
         end
         ST_WIN_START, ST_WIN_CMP: begin
            k_in = (state_ff == ST_WIN_CMP) ? k_ff + KW'(1) : KW'(0);
            if (win_end) begin
               k_in = '0;
               unique case (phase_ff)
                  PH_DIRECT: begin
                     if (win_ok) begin
                        cnt_in    = CW'(MATCH_RUN);
                        mu_in     = 1'b1;
                        ms_in     = 1'b1;
                        mval_in   = 1'b0;
                        streak_in = 1'b1;
                     end else begin
                        i_in     = IW'(1);
                        phase_in = PH_SENT;
                     end
                  end
                  PH_SENT: begin
                     if (win_ok) begin
                        cnt_in  = CW'(i_ff);
                        mu_in   = 1'b0;
                        ms_in   = 1'b1;
                        mval_in = 1'b1;
                     end else begin
                        phase_in = PH_USER;
                     end
                  end
                  PH_USER: begin
                     if (win_ok) begin
                        cnt_in  = CW'(i_ff);
                        mu_in   = 1'b1;
                        ms_in   = 1'b0;
                        mval_in = 1'b1;
                     end else if (i_ff == IW'(LOOKAHEAD)) begin
                        cnt_in  = CW'(1);
                        mu_in   = 1'b1;
                        ms_in   = 1'b1;
                        mval_in = 1'b1;
                     end else begin
                        i_in     = i_ff + IW'(1);
                        phase_in = PH_SENT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MARK: begin
            u_in   = u_ff + PW'(mu_ff);
            s_in   = s_ff + PW'(ms_ff);
            cnt_in = cnt_ff - CW'(1);
         end
         ST_TAIL_U: begin
            if (u_ff < ulen_p) begin
               u_in = u_ff + PW'(1);
            end
         end
         ST_TAIL_S: begin
            if (s_ff < slen_p) begin
               s_in = s_ff + PW'(1);
            end else begin
               done_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ulen_ff  <= '0;
         slen_ff  <= '0;
         ovf_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ulen_ff  <= ulen_in;
         slen_ff  <= slen_in;
         ovf_ff   <= ovf_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      u_ff      <= u_in;
      s_ff      <= s_in;
      streak_ff <= streak_in;
      k_ff      <= k_in;
      i_ff      <= i_in;
      cnt_ff    <= cnt_in;
      mu_ff     <= mu_in;
      ms_ff     <= ms_in;
      mval_ff   <= mval_in;
      rd_op_ff  <= rd_op_in;
      ur_ff     <= ur_in;
      sr_ff     <= sr_in;
   end

   // string buffers
   always_ff @(posedge clock) begin
      if (accept && req_op == OP_APPEND_USER && !user_full) begin
         user_chars[ulen_ff[AW-1:0]] <= fold_upper(req_char_value);
      end
      if (accept && req_op == OP_APPEND_SENT && !sent_full) begin
         sent_chars[slen_ff[AW-1:0]] <= fold_upper(req_char_value);
      end
      uch_ff <= user_chars[rd_u_addr];
      sch_ff <= sent_chars[rd_s_addr];
   end

   // mark buffers
   always_ff @(posedge clock) begin
      if ((state_ff == ST_MARK && mu_ff) || (state_ff == ST_TAIL_U && u_ff < ulen_p)) begin
         user_marks[u_ff[AW-1:0]] <= (state_ff == ST_MARK) ? mval_ff : 1'b1;
      end
      if ((state_ff == ST_MARK && ms_ff) || (state_ff == ST_TAIL_S && s_ff < slen_p)) begin
         sent_marks[s_ff[AW-1:0]] <= (state_ff == ST_MARK) ? mval_ff : 1'b1;
      end
      umk_ff <= user_marks[rd_u_addr];
      smk_ff <= sent_marks[rd_s_addr];
   end

   logic [LW+8:0] ucnt_x, scnt_x;
   assign ucnt_x = {9'(0), ulen_ff};
   assign scnt_x = {9'(0), slen_ff};

   assign rsp_valid         = (state_ff == ST_RESPOND);
   assign rsp_user_style    = rd_op_ff && ur_ff && done_ff && umk_ff;
   assign rsp_sent_style    = rd_op_ff && sr_ff && done_ff && smk_ff;
   assign rsp_user_in_range = rd_op_ff && ur_ff;
   assign rsp_sent_in_range = rd_op_ff && sr_ff;
   assign rsp_user_count    = ucnt_x[8:0];
   assign rsp_sent_count    = scnt_x[8:0];
   assign rsp_overflow      = ovf_ff;
   assign rsp_compared      = done_ff;

endmodule

>>> bench/greedy_text_alignment_marker_core_tb.sv
// testbench for the greedy text alignment marker: directed and random op streams
module greedy_text_alignment_marker_core_tb
   import gtam_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       u_style;
      logic       s_style;
      logic       user_in_range;
      logic       sent_in_range;
      logic [8:0] user_count;
      logic [8:0] sent_count;
      logic       overflow;
      logic       compared;
   } status_type;

   class align_scoreboard;
      logic [7:0] u_buf[256];
      logic [7:0] s_buf[256];
      logic       user_err[256];
      logic       sent_err[256];
      int         u_len;
      int         s_len;
      logic       overflow_seen;
      logic       aligned;
      status_type pending[$];
      int         fails;

      function new();
         u_len = 0;
         s_len = 0;
         overflow_seen = 0;
         aligned = 0;
         fails = 0;
      endfunction

      function logic [7:0] fold_char(logic [7:0] c);
         return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
      endfunction

      function bit window_hit(int u, int s);
         if (u + MatchRunDefault > u_len || s + MatchRunDefault > s_len) return 0;
         for (int k = 0; k < MatchRunDefault; k++)
            if (u_buf[u + k] != s_buf[s + k]) return 0;
         return 1;
      endfunction

      function void align_strings();
         int u;
         int s;
         bit streak;
         bit found;
         u = 0;
         s = 0;
         streak = 0;
         while (u < u_len && s < s_len) begin
            if (streak && u_buf[u] == s_buf[s]) begin
               user_err[u++] = 0;
               sent_err[s++] = 0;
               continue;
            end
            streak = 0;
            if (window_hit(u, s)) begin
               for (int k = 0; k < MatchRunDefault; k++) begin
                  user_err[u + k] = 0;
                  sent_err[s + k] = 0;
               end
               u += MatchRunDefault;
               s += MatchRunDefault;
               streak = 1;
            end else begin
               found = 0;
               for (int i = 1; i <= LookaheadDefault && !found; i++) begin
                  if (window_hit(u, s + i)) begin
                     for (int k = 0; k < i; k++) sent_err[s + k] = 1;
                     s += i;
                     found = 1;
                  end else if (window_hit(u + i, s)) begin
                     for (int k = 0; k < i; k++) user_err[u + k] = 1;
                     u += i;
                     found = 1;
                  end
               end
               if (!found) begin
                  user_err[u++] = 1;
                  sent_err[s++] = 1;
               end
            end
         end
         while (u < u_len) user_err[u++] = 1;
         while (s < s_len) sent_err[s++] = 1;
         aligned = 1;
      endfunction

      function void note_transfer(logic [2:0] op, logic [7:0] ch, logic [7:0] idx);
         status_type e;
         e = '0;
         case (op)
            OP_APPEND_USER: begin
               if (u_len < MaxLenDefault) begin
                  u_buf[u_len++] = fold_char(ch);
                  aligned = 0;
               end else overflow_seen = 1;
            end
            OP_APPEND_SENT: begin
               if (s_len < MaxLenDefault) begin
                  s_buf[s_len++] = fold_char(ch);
                  aligned = 0;
               end else overflow_seen = 1;
            end
            OP_COMPARE: align_strings();
            OP_READ: begin
               e.user_in_range = idx < u_len;
               e.sent_in_range = idx < s_len;
               if (aligned) begin
                  if (e.user_in_range) e.u_style = user_err[idx];
                  if (e.sent_in_range) e.s_style = sent_err[idx];
               end
            end
            OP_CLEAR: begin
               u_len = 0;
               s_len = 0;
               overflow_seen = 0;
               aligned = 0;
            end
            default: ;
         endcase
         e.user_count = u_len[8:0];
         e.sent_count = s_len[8:0];
         e.overflow = overflow_seen;
         e.compared = aligned;
         pending.push_back(e);
      endfunction

      function void check_result(status_type got);
         status_type e;
         if (pending.size() == 0) begin
            $error("result with no transfer waiting");
            fails++;
            return;
         end
         e = pending.pop_front();
         if (got.u_style !== e.u_style) begin
            $error("rsp_user_style expected %0d got %0d", e.u_style, got.u_style); fails++;
         end
         if (got.s_style !== e.s_style) begin
            $error("rsp_sent_style expected %0d got %0d", e.s_style, got.s_style); fails++;
         end
         if (got.user_in_range !== e.user_in_range) begin
            $error("user_in_range expected %0d got %0d", e.user_in_range, got.user_in_range);
            fails++;
         end
         if (got.sent_in_range !== e.sent_in_range) begin
            $error("sent_in_range expected %0d got %0d", e.sent_in_range, got.sent_in_range);
            fails++;
         end
         if (got.user_count !== e.user_count) begin
            $error("user_count expected %0d got %0d", e.user_count, got.user_count); fails++;
         end
         if (got.sent_count !== e.sent_count) begin
            $error("sent_count expected %0d got %0d", e.sent_count, got.sent_count); fails++;
         end
         if (got.overflow !== e.overflow) begin
            $error("overflow expected %0d got %0d", e.overflow, got.overflow); fails++;
         end
         if (got.compared !== e.compared) begin
            $error("compared expected %0d got %0d", e.compared, got.compared); fails++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_op;
   logic [7:0] req_char_value;
   logic [7:0] req_index;
   logic       rsp_valid;
   logic       rsp_user_style;
   logic       rsp_sent_style;
   logic       rsp_user_in_range;
   logic       rsp_sent_in_range;
   logic [8:0] rsp_user_count;
   logic [8:0] rsp_sent_count;
   logic       rsp_overflow;
   logic       rsp_compared;

   align_scoreboard sb;
   int items;
   int idle_pct;
   int cycles;

   greedy_text_alignment_marker_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_char_value(req_char_value), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_user_style(rsp_user_style),
      .rsp_sent_style(rsp_sent_style), .rsp_user_in_range(rsp_user_in_range),
      .rsp_sent_in_range(rsp_sent_in_range), .rsp_user_count(rsp_user_count),
      .rsp_sent_count(rsp_sent_count), .rsp_overflow(rsp_overflow),
      .rsp_compared(rsp_compared)
   );

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_user_style, rsp_sent_style, rsp_user_in_range,
                           rsp_sent_in_range, rsp_user_count, rsp_sent_count,
                           rsp_overflow, rsp_compared});
   end

   task automatic send(logic [2:0] op, logic [7:0] ch, logic [7:0] idx);
      start <= 1;
      req_op <= op;
      req_char_value <= ch;
      req_index <= idx;
      do @(posedge clock); while (busy);
      sb.note_transfer(op, ch, idx);
      items++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 8'h41 + 8'($urandom_range(0, 3));
      if (r < 70) return 8'h61 + 8'($urandom_range(0, 3));
      if (r < 75) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   task automatic aligned_sequence(int max_len);
      logic [7:0] ut[$];
      logic [7:0] st[$];
      logic [7:0] c;
      int len;
      int hi;
      int r;
      ut = {};
      st = {};
      len = $urandom_range(0, max_len);
      for (int i = 0; i < len; i++) ut.push_back(pick_char());
      foreach (ut[i]) begin
         r = $urandom_range(99);
         c = ut[i];
         if (r < 60) st.push_back((c >= 8'h41 && c <= 8'h5a && r < 20) ? c + 8'h20 : c);
         else if (r < 75) st.push_back(pick_char());
         else if (r < 90) begin
            st.push_back(pick_char());
            st.push_back(c);
         end
      end
      send(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
      while (ut.size() != 0 || st.size() != 0) begin
         if (st.size() == 0 || (ut.size() != 0 && $urandom_range(1)))
            send(OP_APPEND_USER, ut.pop_front(), 8'($urandom_range(255)));
         else
            send(OP_APPEND_SENT, st.pop_front(), 8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0) send(OP_READ, 8'h00, 8'h00);
      send(OP_COMPARE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) send(OP_APPEND_SENT, pick_char(), 8'h00);
      hi = (sb.u_len > sb.s_len ? sb.u_len : sb.s_len) + 1;
      if (hi > 255) hi = 255;
      for (int i = 0; i <= hi; i++) send(OP_READ, 8'($urandom_range(255)), i[7:0]);
      send(OP_READ, pick_char(), 8'($urandom_range(255)));
   endtask

   task automatic full_sequence();
      send(OP_CLEAR, 8'h00, 8'h00);
      for (int i = 0; i < 258; i++) send(OP_APPEND_USER, pick_char(), 8'h00);
      for (int i = 0; i < 258; i++) send(OP_APPEND_SENT, pick_char(), 8'h00);
      send(OP_COMPARE, 8'h00, 8'h00);
      send(OP_READ, 8'h00, 8'hff);
      send(OP_READ, 8'h00, 8'h00);
      for (int i = 0; i < 6; i++) send(OP_READ, 8'h00, 8'($urandom_range(255)));
   endtask

   initial begin
      sb = new();
      items = 0;
      idle_pct = 0;
      reset = 1;
      start = 0;
      req_op = OP_CLEAR;
      req_char_value = 0;
      req_index = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: folding, zero byte, end windows, unused ops, reads before compare
      send(OP_READ, 8'h00, 8'h00);
      send(OP_APPEND_USER, 8'h61, 8'h00);
      send(OP_APPEND_USER, 8'h7a, 8'h00);
      send(OP_APPEND_USER, 8'h60, 8'h00);
      send(OP_APPEND_USER, 8'h00, 8'h00);
      send(OP_APPEND_USER, 8'hff, 8'h00);
      send(OP_APPEND_SENT, 8'h41, 8'h00);
      send(OP_APPEND_SENT, 8'h5a, 8'h00);
      send(OP_APPEND_SENT, 8'h7b, 8'h00);
      send(OP_APPEND_SENT, 8'h00, 8'h00);
      send(OP_READ, 8'h00, 8'h01);
      send(OP_COMPARE, 8'h00, 8'h00);
      for (int i = 0; i < 6; i++) send(OP_READ, 8'h00, i[7:0]);
      send(OP_READ, 8'hff, 8'hff);
      send(3'd5, 8'hff, 8'hff);
      send(3'd6, 8'h00, 8'h00);
      send(3'd7, 8'h55, 8'haa);
      send(OP_CLEAR, 8'h00, 8'h00);
      send(OP_COMPARE, 8'h00, 8'h00);
      send(OP_READ, 8'h00, 8'h00);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = ph == 0 ? 8 : (ph == 1 ? 58 : 0);
         if (ph == 0) full_sequence();
         while (items < 330 * (ph + 1) + 30) begin
            if ($urandom_range(99) < 85)
               aligned_sequence($urandom_range(9) == 0 ? 40 : 12);
            else
               repeat ($urandom_range(1, 5))
                  send(3'($urandom_range(7)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
         end
         drain();
      end

      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.fails == 0 && sb.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
